>>> rtl/assert_macros.svh
// assertion macros for the order book matcher
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> rtl/obm_pkg.sv
// shared types and constants for the order book matcher
// no dependencies
package obm_pkg;
    localparam int BookSlotsDefault = 64;
    localparam int MaxResults = 64;

    localparam logic [1:0] KIND_FILL = 2'd0;
    localparam logic [1:0] KIND_NOFILL = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_FULL = 2'd3;

    localparam logic CMD_ADD_ASK = 1'b0;
    localparam logic CMD_BUY = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] ord_ref;
        logic [31:0] limit_price;
        logic [30:0] quantity;
        logic        is_market;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] maker_id;
        logic [31:0] taker_id;
        logic [31:0] trade_px;
        logic [30:0] trade_qty;
        logic [30:0] maker_left;
        logic [30:0] taker_left;
        logic        maker_done;
        logic        taker_done;
        logic        last;
    } t_out_word;

    // one compare of the scan unit: candidate against running best
    typedef struct packed {
        logic [31:0] price;
        logic [31:0] age;
    } t_key;
endpackage

>>> rtl/obm_cmp.sv
// price-time priority compare used by the scan sequencer
// depends on obm_pkg
module obm_cmp import obm_pkg::*; (
    input  t_key i_cand,
    input  t_key i_best,
    input  logic i_have_best,
    output logic o_better
);
    assign o_better = !i_have_best || (i_cand.price < i_best.price) ||
                      ((i_cand.price == i_best.price) && (i_cand.age > i_best.age));
endmodule

>>> rtl/order_book_buy_matcher.sv
// iterative ask book matcher: one slot a cycle over a shared compare unit
// add_ask: the result word leaves the cycle after accept, next word once it drains
// buy: each decision scans every slot, then drains, reads and fills; after each fill it waits
// to hand off the word, plus output stalls; up to MaxResults fills, each word held one decision
// the book slot memory has one read port, which sets the one-slot-per-cycle scan
// reset (synchronous, active low) empties the book and clears the arrival counter
module order_book_buy_matcher import obm_pkg::*; #(
    parameter int BOOK_SLOTS = BookSlotsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);
    localparam int IW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
    localparam int CW = $clog2(BOOK_SLOTS + 1);
    localparam int NW = $clog2(MaxResults + 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;   // issue reads, slot per cycle
    localparam logic [2:0] ST_DRAIN = 3'd2;  // last read data arrives
    localparam logic [2:0] ST_READ = 3'd3;   // read the winning slot
    localparam logic [2:0] ST_FILL = 3'd4;   // compute fill, write back
    localparam logic [2:0] ST_OUT = 3'd5;    // wait for the word to leave

    // slot memory, one entry per ask: price, owner, remainder, arrival
    typedef struct packed {
        logic [31:0] price;
        logic [31:0] owner;
        logic [30:0] left;
        logic [31:0] arrival;
    } t_slot;

    t_slot mem [BOOK_SLOTS];
    t_slot r_rd;
    logic [IW-1:0] n_rd_addr;
    logic          n_we;
    logic [IW-1:0] n_wr_addr;
    t_slot         n_wr_data;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[n_wr_addr] <= n_wr_data;
        end
        r_rd <= mem[n_rd_addr];
    end

    logic [BOOK_SLOTS-1:0] r_valid, n_valid;
    logic [2:0]   r_state, n_state;
    logic [31:0]  r_arrival_cnt, n_arrival_cnt;
    t_in_word     r_item, n_item;
    logic [CW-1:0] r_idx, n_idx;        // next slot to read
    logic [IW-1:0] r_cand, n_cand;      // slot whose data sits in r_rd
    logic          r_cand_ok, n_cand_ok;
    logic          r_have, n_have;
    logic [IW-1:0] r_best, n_best;
    t_key          r_best_key, n_best_key;
    logic [NW-1:0] r_nfill, n_nfill;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;

    // free slot: lowest clear valid bit, searched with priority if over bits
    logic          free_found;
    logic [IW-1:0] free_slot;
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = BOOK_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_slot  = IW'(i);
            end
        end
    end

    // shared compare unit
    t_key cand_key;
    logic better;
    assign cand_key.price = r_rd.price;
    assign cand_key.age   = r_arrival_cnt - r_rd.arrival;
    obm_cmp u_cmp (
        .i_cand      (cand_key),
        .i_best      (r_best_key),
        .i_have_best (r_have),
        .o_better    (better)
    );

    logic [30:0] fill_q, mk_left, tk_left;
    assign fill_q  = (r_item.quantity < r_rd.left) ? r_item.quantity : r_rd.left;
    assign mk_left = r_rd.left - fill_q;
    assign tk_left = r_item.quantity - fill_q;

    assign o_in_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_arrival_cnt = r_arrival_cnt;
        n_item        = r_item;
        n_idx         = r_idx;
        n_cand        = r_cand;
        n_cand_ok     = 1'b0;
        n_have        = r_have;
        n_best        = r_best;
        n_best_key    = r_best_key;
        n_nfill       = r_nfill;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        n_rd_addr     = r_idx[IW-1:0];
        n_we          = 1'b0;
        n_wr_addr     = free_slot;
        n_wr_data     = '0;

        // fold the candidate read last cycle into the running best
        if ((r_state == ST_SCAN || r_state == ST_DRAIN) && r_cand_ok && better) begin
            n_have           = 1'b1;
            n_best           = r_cand;
            n_best_key       = cand_key;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_item = i_in_data;
                    n_out  = '0;
                    if (i_in_data.command == CMD_ADD_ASK) begin
                        n_out.maker_id = i_in_data.ord_ref;
                        n_out.last     = 1'b1;
                        n_out_valid    = 1'b1;
                        if (i_in_data.quantity == '0) begin
                            n_out.kind = KIND_ACCEPT;
                        end else if (!free_found) begin
                            n_out.kind = KIND_FULL;
                        end else begin
                            n_out.kind       = KIND_ACCEPT;
                            n_out.maker_left = i_in_data.quantity;
                            n_we             = 1'b1;
                            n_wr_data.price   = i_in_data.limit_price;
                            n_wr_data.owner   = i_in_data.ord_ref;
                            n_wr_data.left    = i_in_data.quantity;
                            n_wr_data.arrival = r_arrival_cnt;
                            n_valid[free_slot] = 1'b1;
                            n_arrival_cnt      = r_arrival_cnt + 32'd1;
                        end
                    end else begin
                        n_nfill = '0;
                        n_idx   = '0;
                        n_have  = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_rd_addr = r_idx[IW-1:0];
                n_cand    = r_idx[IW-1:0];
                n_cand_ok = r_valid[r_idx[IW-1:0]];
                n_idx     = r_idx + CW'(1);
                if (r_idx == CW'(BOOK_SLOTS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_rd_addr = r_best;
                n_state   = ST_READ;
            end
            ST_READ: begin
                // n_have/n_best include the last candidate now
                n_rd_addr = r_best;
                n_state   = ST_FILL;
            end
            ST_FILL: begin
                n_out = '0;
                n_out.taker_id = r_item.ord_ref;
                if (r_item.quantity == '0 || !r_have ||
                    (!r_item.is_market && r_rd.price > r_item.limit_price) ||
                    r_nfill == NW'(MaxResults)) begin
                    if (r_nfill == '0) begin
                        n_out.kind       = KIND_NOFILL;
                        n_out.taker_left = r_item.quantity;
                        n_out.maker_done = (r_item.quantity == '0);
                        n_out.taker_done = (r_item.quantity == '0);
                        n_out.last       = 1'b1;
                        n_out_valid      = 1'b1;
                    end
                    n_state = ST_IDLE;
                end else begin
                    n_out.kind          = KIND_FILL;
                    n_out.maker_id      = r_rd.owner;
                    n_out.trade_px      = r_rd.price;
                    n_out.trade_qty     = fill_q;
                    n_out.maker_left    = mk_left;
                    n_out.taker_left    = tk_left;
                    n_out.maker_done    = (mk_left == '0);
                    n_out.taker_done    = (tk_left == '0);
                    n_we                = 1'b1;
                    n_wr_addr           = r_best;
                    n_wr_data           = r_rd;
                    n_wr_data.left      = mk_left;
                    if (mk_left == '0) begin
                        n_valid[r_best] = 1'b0;
                    end
                    n_item.quantity = tk_left;
                    n_nfill         = r_nfill + NW'(1);
                    n_state         = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait until the word handed over in fill has left,
                // so the output register is free at the next fill
                if (out_free) begin
                    n_idx       = '0;
                    n_have      = 1'b0;
                    n_state     = ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // pending fill buffer: fill words wait here until the next scan tells
    // whether another fill follows, which sets last
    t_out_word r_pend, n_pend;
    logic      r_pend_ok, n_pend_ok;
    t_out_word out_sel;
    logic      out_sel_valid;

    always_comb begin
        n_pend    = r_pend;
        n_pend_ok = r_pend_ok;
        out_sel       = n_out;
        out_sel_valid = n_out_valid;
        if (r_state == ST_FILL) begin
            if (n_state == ST_OUT) begin
                // new fill: previous pending goes out as not last
                out_sel_valid = r_pend_ok;
                out_sel       = r_pend;
                out_sel.last  = 1'b0;
                n_pend        = n_out;
                n_pend_ok     = 1'b1;
            end else if (r_pend_ok) begin
                out_sel_valid = 1'b1;
                out_sel       = r_pend;
                out_sel.last  = 1'b1;
                n_pend_ok     = 1'b0;
            end
        end else if (r_state == ST_OUT) begin
            out_sel_valid = r_out_valid && i_out_stall;
            out_sel       = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_valid       <= '0;
            r_arrival_cnt <= '0;
            r_out_valid   <= 1'b0;
            r_cand_ok     <= 1'b0;
            r_have        <= 1'b0;
            r_pend_ok     <= 1'b0;
            r_nfill       <= '0;
            r_idx         <= '0;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_arrival_cnt <= n_arrival_cnt;
            r_out_valid   <= out_sel_valid;
            r_cand_ok     <= n_cand_ok;
            r_have        <= n_have;
            r_pend_ok     <= n_pend_ok;
            r_nfill       <= n_nfill;
            r_idx         <= n_idx;
        end
        r_item     <= n_item;
        r_cand     <= n_cand;
        r_best     <= n_best;
        r_best_key <= n_best_key;
        r_out      <= out_sel;
        r_pend     <= n_pend;
    end

    `include "assert_macros.svh"

    // no new word is taken while a buy is being worked
    `ASSERT_CLK(a_busy_stall, i_clk, i_rst_n, (r_state != ST_IDLE) |-> o_in_stall, "busy accept")
    // a fill count never passes the result limit
    `ASSERT_CLK(a_fill_limit, i_clk, i_rst_n, r_nfill <= NW'(MaxResults), "fill limit exceeded")
    // a pending fill only exists during a buy
    `ASSERT_CLK(a_pend_buy, i_clk, i_rst_n, r_pend_ok |-> (r_state != ST_IDLE), "stray pending fill")
endmodule
